### hw/rtl/tmdg_pkg.sv
// Package for the TSC mass deposit grid: sizes, item and internal types.
// Used by every module under hw/rtl; depends on nothing.
package tmdg_pkg;

  localparam int MAX_GRID_X = 256;
  localparam int MAX_GRID_Y = 256;
  localparam int COL_W      = $clog2(MAX_GRID_X);
  localparam int ROW_W      = $clog2(MAX_GRID_Y);
  localparam int ADDR_W     = COL_W + ROW_W;
  localparam int IDX_W      = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int SIZE_W     = 9;
  localparam int ACC_W      = 48;
  localparam int ENTRY_W    = ACC_W + 1;

  localparam logic [ACC_W-1:0] ACC_MAX     = {ACC_W{1'b1}};
  localparam logic [31:0]      HALF_Q32    = 32'h8000_0000;
  localparam logic [31:0]      THREE_Q_Q32 = 32'hC000_0000;

  localparam logic OP_DEPOSIT = 1'b0;
  localparam logic OP_READ    = 1'b1;

  localparam logic [1:0] REG_GRID_WIDTH    = 2'd0;
  localparam logic [1:0] REG_GRID_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_INV_CELL_SIZE = 2'd2;
  localparam logic [1:0] REG_MASS_SCALE    = 2'd3;

  typedef struct packed {
    logic               opcode;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [31:0]        particle_mass;
    logic [7:0]         read_col;
    logic [7:0]         read_row;
  } in_item_t;

  typedef struct packed {
    logic [ACC_W-1:0] cell_value;
    logic             cell_saturated;
  } out_item_t;

  typedef struct packed {
    logic                  ok;
    logic [2:0][IDX_W-1:0] idx;   // nearest, toward, away
    logic [2:0][31:0]      w;
  } axis_res_t;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
    logic [31:0]       wx;
    logic [31:0]       wy;
  } cell_req_t;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
  } rd_req_t;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
    logic [ACC_W-1:0]  c;
  } cell_upd_t;

endpackage

### hw/rtl/tmdg_axis.sv
// One axis of the TSC deposit: scale, round to nearest (ties even), indices, weights.
// Fixed four-stage pipeline; depends on tmdg_pkg.
module tmdg_axis import tmdg_pkg::*; (
  input  logic               clk,
  input  logic signed [31:0] pos,
  input  logic [31:0]        inv,
  input  logic [SIZE_W-1:0]  size,
  output axis_res_t          res
);

  localparam int NW = 34;
  localparam int SW = SIZE_W + 2;

  function automatic logic [IDX_W-1:0] wrap_idx(input logic signed [SW-1:0] t,
                                                 input logic signed [SW-1:0] s);
    logic signed [SW-1:0] r;
    begin
      r = t;
      if (t < 0) r = t + s;
      else if (t >= s) r = t - s;
      wrap_idx = r[IDX_W-1:0];
    end
  endfunction

  logic [31:0] mag;
  logic        neg1_r;
  logic [63:0] prod1_r;

  assign mag = pos[31] ? (32'd0 - pos) : pos;

  always_ff @(posedge clk) begin
    neg1_r  <= pos[31];
    prod1_r <= mag * inv;
  end

  // stage 2: nearest cell and offset
  logic [31:0]          hi, lo, f, a;
  logic                 lo_nz, up, ok;
  logic [32:0]          c33;
  logic signed [NW-1:0] n0, n1, lo_b, hi_b;

  always_comb begin
    hi    = prod1_r[63:32];
    lo    = prod1_r[31:0];
    lo_nz = (lo != 32'd0);
    c33   = {1'b0, hi} + {32'd0, lo_nz};
    n0    = neg1_r ? -$signed({1'b0, c33}) : $signed({2'b00, hi});
    f     = neg1_r ? (lo_nz ? (32'd0 - lo) : 32'd0) : lo;
    up    = (f > HALF_Q32) || ((f == HALF_Q32) && n0[0]);
    n1    = n0 + $signed({{(NW-1){1'b0}}, up});
    a     = up ? (32'd0 - f) : f;
    lo_b  = $signed({{(NW-SIZE_W){1'b0}}, 9'd1}) - $signed({{(NW-SIZE_W){1'b0}}, size});
    hi_b  = $signed({{(NW-SIZE_W-1){1'b0}}, size, 1'b0}) - 34'sd2;
    ok    = (n1 >= lo_b) && (n1 <= hi_b);
  end

  logic                 ok2_r, up2_r;
  logic [31:0]          a2_r;
  logic signed [SW-1:0] n2_r;

  always_ff @(posedge clk) begin
    ok2_r <= ok;
    up2_r <= up;
    a2_r  <= a;
    n2_r  <= n1[SW-1:0];
  end

  // stage 3: wrapped indices, squares
  logic signed [SW-1:0] s_s, t1, t2;
  logic [31:0]          u;

  assign s_s = $signed({2'b00, size});
  assign t1  = up2_r ? (n2_r - 11'sd1) : (n2_r + 11'sd1);
  assign t2  = up2_r ? (n2_r + 11'sd1) : (n2_r - 11'sd1);
  assign u   = HALF_Q32 - a2_r;

  logic                  ok3_r;
  logic [2:0][IDX_W-1:0] idx3_r;
  logic [63:0]           uu3_r, aa3_r;
  logic [31:0]           a3_r;

  always_ff @(posedge clk) begin
    ok3_r     <= ok2_r;
    idx3_r[0] <= wrap_idx(n2_r, s_s);
    idx3_r[1] <= wrap_idx(t1, s_s);
    idx3_r[2] <= wrap_idx(t2, s_s);
    uu3_r     <= u * u;
    aa3_r     <= a2_r * a2_r;
    a3_r      <= a2_r;
  end

  // stage 4: weights
  logic [31:0] wa;
  assign wa = {1'b0, uu3_r[63:33]};

  always_ff @(posedge clk) begin
    res.ok   <= ok3_r;
    res.idx  <= idx3_r;
    res.w[2] <= wa;
    res.w[1] <= wa + a3_r;
    res.w[0] <= THREE_Q_Q32 - aa3_r[63:32];
  end

endmodule

### hw/rtl/tmdg_contrib.sv
// Per-cell contribution pipeline: weight product, times mass, clip to 48 bits.
// Three stages, one cell per cycle; depends on tmdg_pkg.
module tmdg_contrib import tmdg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cell_req_t   req,
  input  logic [63:0] pmass,
  output rd_req_t     rd,
  output cell_upd_t   upd,
  output logic        busy
);

  logic              v1_r, v2_r;
  logic [ADDR_W-1:0] addr1_r, addr2_r;
  logic [63:0]       wprod;
  logic [31:0]       w1_r;
  logic [63:0]       mh2_r, ml2_r;
  logic [64:0]       csum;

  assign wprod = req.wx * req.wy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      upd.valid <= 1'b0;
    end else begin
      v1_r      <= req.valid;
      v2_r      <= v1_r;
      upd.valid <= v2_r;
    end
  end

  assign csum = {1'b0, mh2_r} + {33'd0, ml2_r[63:32]};

  always_ff @(posedge clk) begin
    addr1_r  <= req.addr;
    w1_r     <= wprod[63:32];
    addr2_r  <= addr1_r;
    mh2_r    <= pmass[63:32] * w1_r;
    ml2_r    <= pmass[31:0] * w1_r;
    upd.addr <= addr2_r;
    upd.c    <= (csum > {17'd0, ACC_MAX}) ? ACC_MAX : csum[ACC_W-1:0];
  end

  assign rd.valid = v2_r;
  assign rd.addr  = addr2_r;
  assign busy     = v1_r | v2_r | upd.valid;

endmodule

### hw/rtl/tmdg_grid_mem.sv
// Grid store: one write port, one read port, registered read data (old data on collision).
// Depends on tmdg_pkg.
module tmdg_grid_mem import tmdg_pkg::*; (
  input  logic               clk,
  input  logic               we,
  input  logic [ADDR_W-1:0]  waddr,
  input  logic [ENTRY_W-1:0] wdata,
  input  logic               re,
  input  logic [ADDR_W-1:0]  raddr,
  output logic [ENTRY_W-1:0] rdata
);

  logic [ENTRY_W-1:0] mem [MAX_GRID_X*MAX_GRID_Y];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

### hw/rtl/tsc_mass_deposit_grid_unit.sv
// Top level of the TSC mass deposit grid.
// Depends on tmdg_pkg, tmdg_axis, tmdg_contrib and tmdg_grid_mem.
//
// Usage:
// - Input channel (in_valid/in_stall/in_item): one item is a deposit
//   (opcode 0) or a read-and-clear of one cell (opcode 1).
// - Output channel (out_valid/out_stall/out_item): one item per read,
//   none per deposit. The output register lets the next input item be
//   taken while a read result still waits.
// - Config port: cfg_we/cfg_index/cfg_wdata, write only, idle time only.
// - Sequence: a deposit is accepted, passes the axis pipeline, if in range
//   issues nine cells into the read-modify-write pipe on the grid memory
//   and drains. A read is issued to the grid memory, then sent to out_item.
//   All cells share the single grid memory port pair.
// - Reset: registers return to 256/256/1.0/1.0, then a clearing pass
//   writes zero to all 65536 entries, one per cycle; in_stall stays high
//   until the pass ends.
// - A stalled receiver holds out_item; a read item then waits inside the
//   block until the output register frees.
module tsc_mass_deposit_grid_unit import tmdg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam logic [2:0] ST_CLR    = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_AXIS   = 3'd2;
  localparam logic [2:0] ST_CELLS  = 3'd3;
  localparam logic [2:0] ST_DRAIN  = 3'd4;
  localparam logic [2:0] ST_RD_ISS = 3'd5;
  localparam logic [2:0] ST_RD_OUT = 3'd6;

  // configuration
  logic [SIZE_W-1:0] grid_width_r, grid_height_r, wdt, hgt;
  logic [31:0]       inv_cell_size_r, mass_scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r    <= 9'd256;
      grid_height_r   <= 9'd256;
      inv_cell_size_r <= 32'd65536;
      mass_scale_r    <= 32'd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRID_WIDTH:    grid_width_r    <= cfg_wdata[SIZE_W-1:0];
        REG_GRID_HEIGHT:   grid_height_r   <= cfg_wdata[SIZE_W-1:0];
        REG_INV_CELL_SIZE: inv_cell_size_r <= cfg_wdata;
        REG_MASS_SCALE:    mass_scale_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sizes in use, clamped to 1..max
  assign wdt = (grid_width_r == '0) ? SIZE_W'(1) :
               (grid_width_r > SIZE_W'(MAX_GRID_X)) ? SIZE_W'(MAX_GRID_X) : grid_width_r;
  assign hgt = (grid_height_r == '0) ? SIZE_W'(1) :
               (grid_height_r > SIZE_W'(MAX_GRID_Y)) ? SIZE_W'(MAX_GRID_Y) : grid_height_r;

  // control
  logic [2:0]        state_r, state_nxt;
  logic [1:0]        wait_r, wait_nxt, i_r, i_nxt, j_r, j_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;
  in_item_t          item_r;
  logic [63:0]       pmass_r;
  logic              in_fire, out_free, rd_done;

  axis_res_t ax, ay;
  cell_req_t req;
  rd_req_t   crd;
  cell_upd_t upd;
  logic      cbusy;

  assign in_stall = (state_r != ST_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign rd_done  = (state_r == ST_RD_OUT) && out_free;

  always_comb begin
    state_nxt = state_r;
    wait_nxt  = wait_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    clr_nxt   = clr_r;
    unique case (state_r)
      ST_CLR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == {ADDR_W{1'b1}}) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        wait_nxt = 2'd0;
        i_nxt    = 2'd0;
        j_nxt    = 2'd0;
        if (in_fire) state_nxt = (in_item.opcode == OP_READ) ? ST_RD_ISS : ST_AXIS;
      end
      ST_AXIS: begin
        wait_nxt = wait_r + 1'b1;
        if (wait_r == 2'd3) state_nxt = ST_CELLS;
      end
      ST_CELLS: begin
        if (!(ax.ok && ay.ok)) begin
          state_nxt = ST_IDLE;
        end else if (i_r == 2'd2) begin
          i_nxt = 2'd0;
          j_nxt = j_r + 1'b1;
          if (j_r == 2'd2) state_nxt = ST_DRAIN;
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end
      ST_DRAIN:  if (!cbusy) state_nxt = ST_IDLE;
      ST_RD_ISS: state_nxt = ST_RD_OUT;
      ST_RD_OUT: if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      clr_r   <= '0;
      wait_r  <= 2'd0;
      i_r     <= 2'd0;
      j_r     <= 2'd0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      wait_r  <= wait_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) item_r <= in_item;
    pmass_r <= mass_scale_r * item_r.particle_mass;
  end

  // per-axis weights
  tmdg_axis u_ax (
    .clk  (clk),
    .pos  (item_r.pos_x),
    .inv  (inv_cell_size_r),
    .size (wdt),
    .res  (ax)
  );

  tmdg_axis u_ay (
    .clk  (clk),
    .pos  (item_r.pos_y),
    .inv  (inv_cell_size_r),
    .size (hgt),
    .res  (ay)
  );

  // cell issue: y outer, x inner
  logic [IDX_W-1:0] col_sel, row_sel;
  always_comb begin
    col_sel   = ax.idx[i_r];
    row_sel   = ay.idx[j_r];
    req.valid = (state_r == ST_CELLS) && ax.ok && ay.ok;
    req.addr  = {row_sel[ROW_W-1:0], col_sel[COL_W-1:0]};
    req.wx    = ax.w[i_r];
    req.wy    = ay.w[j_r];
  end

  tmdg_contrib u_contrib (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .pmass (pmass_r),
    .rd    (crd),
    .upd   (upd),
    .busy  (cbusy)
  );

  // grid memory and read-modify-write
  logic               m_we, m_re;
  logic [ADDR_W-1:0]  m_waddr, m_raddr, rd_addr;
  logic [ENTRY_W-1:0] m_wdata, m_rdata, base, upd_word;
  logic [ACC_W:0]     sum;
  logic               fwd_hit_r;
  logic [ENTRY_W-1:0] fwd_data_r;

  assign rd_addr = {item_r.read_row[ROW_W-1:0], item_r.read_col[COL_W-1:0]};
  assign base    = fwd_hit_r ? fwd_data_r : m_rdata;
  assign sum     = {1'b0, base[ENTRY_W-1:1]} + {1'b0, upd.c};

  always_comb begin
    if (sum >= {1'b0, ACC_MAX}) upd_word = {ACC_MAX, 1'b1};
    else                        upd_word = {sum[ACC_W-1:0], base[0]};
  end

  always_comb begin
    m_re    = crd.valid || (state_r == ST_RD_ISS);
    m_raddr = crd.valid ? crd.addr : rd_addr;
    m_we    = 1'b0;
    m_waddr = upd.addr;
    m_wdata = upd_word;
    if (state_r == ST_CLR) begin
      m_we    = 1'b1;
      m_waddr = clr_r;
      m_wdata = '0;
    end else if (rd_done) begin
      m_we    = 1'b1;
      m_waddr = rd_addr;
      m_wdata = '0;
    end else if (upd.valid) begin
      m_we = 1'b1;
    end
  end

  // a write landing on the entry read in the same cycle is forwarded
  always_ff @(posedge clk) begin
    if (!rst_n) fwd_hit_r <= 1'b0;
    else        fwd_hit_r <= m_re && m_we && (m_waddr == m_raddr);
    fwd_data_r <= m_wdata;
  end

  tmdg_grid_mem u_mem (
    .clk   (clk),
    .we    (m_we),
    .waddr (m_waddr),
    .wdata (m_wdata),
    .re    (m_re),
    .raddr (m_raddr),
    .rdata (m_rdata)
  );

  // output register
  logic out_valid_r;
  always_ff @(posedge clk) begin
    if (!rst_n)            out_valid_r <= 1'b0;
    else if (rd_done)      out_valid_r <= 1'b1;
    else if (!out_stall)   out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rd_done) begin
      out_item.cell_value     <= m_rdata[ENTRY_W-1:1];
      out_item.cell_saturated <= m_rdata[0];
    end
  end

  assign out_valid = out_valid_r;

endmodule

### sim/tmdg_density_checker.sv
`timescale 1ns / 1ps
// Passive checker for tsc_mass_deposit_grid_unit: keeps its own density grid,
// predicts each read result and compares it with the output channel.
// Depends on tmdg_pkg.
module tmdg_density_checker import tmdg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_item_t    in_item,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_item_t   out_item,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  output int          fail_count,
  output int          reads_pending
);

  typedef struct packed {
    logic             ok;
    logic [2:0][8:0]  idx;   // nearest, toward, away
    logic [2:0][31:0] w;
  } axis_pred_t;

  logic [ACC_W-1:0] grid_acc [MAX_GRID_X*MAX_GRID_Y];
  logic             grid_sat [MAX_GRID_X*MAX_GRID_Y];
  logic [8:0]       cur_width, cur_height;
  logic [31:0]      cur_inv_cell, cur_mass_scale;
  out_item_t        read_results_q [$];

  initial begin
    fail_count = 0;
    for (int k = 0; k < MAX_GRID_X*MAX_GRID_Y; k++) begin
      grid_acc[k] = '0;
      grid_sat[k] = 1'b0;
    end
  end

  assign reads_pending = read_results_q.size();

  function automatic int clamp_size(input logic [8:0] v, input int maxv);
    if (v == 0) return 1;
    if (int'(v) > maxv) return maxv;
    return int'(v);
  endfunction

  // One axis: round to nearest cell (ties to even), TSC weights in Q0.32.
  function automatic axis_pred_t axis_weights(input logic [31:0] raw, input int size);
    axis_pred_t           res;
    longint unsigned      mag, prod, f, a, c, u, wa;
    longint               n, side, ix;
    bit                   neg;
    neg  = raw[31];
    mag  = neg ? (64'h1_0000_0000 - {32'b0, raw}) : {32'b0, raw};
    prod = mag * {32'b0, cur_inv_cell};
    if (!neg) begin
      n = longint'(prod >> 32);
      f = prod & 64'hFFFF_FFFF;
    end else begin
      c = (prod + 64'hFFFF_FFFF) >> 32;
      n = -longint'(c);
      f = (c << 32) - prod;
    end
    if (f > 64'h8000_0000 || (f == 64'h8000_0000 && n[0])) begin
      n    = n + 1;
      a    = 64'h1_0000_0000 - f;
      side = -1;
    end else begin
      a    = f;
      side = 1;
    end
    res = '0;
    if (n < 1 - size || n > 2 * size - 2) return res;
    res.ok = 1'b1;
    for (int k = 0; k < 3; k++) begin
      ix = (k == 0) ? n : (k == 1) ? n + side : n - side;
      if (ix < 0) ix = ix + size;
      else if (ix >= size) ix = ix - size;
      res.idx[k] = ix[8:0];
    end
    u  = 64'h8000_0000 - a;
    wa = (u * u) >> 33;
    res.w[2] = wa[31:0];
    res.w[1] = 32'(wa + a);
    res.w[0] = 32'(64'hC000_0000 - ((a * a) >> 32));
    return res;
  endfunction

  function automatic void add_to_cell(input int col, input int row,
                                      input longint unsigned pmass,
                                      input logic [31:0] wx, input logic [31:0] wy);
    longint unsigned w, c, total;
    int              at;
    w  = ({32'b0, wx} * {32'b0, wy}) >> 32;
    c  = (pmass >> 32) * w + (((pmass & 64'hFFFF_FFFF) * w) >> 32);
    at = row * MAX_GRID_X + col;
    if (c > 64'(ACC_MAX)) c = 64'(ACC_MAX);
    total = 64'(grid_acc[at]) + c;
    if (total >= 64'(ACC_MAX)) begin
      total        = 64'(ACC_MAX);
      grid_sat[at] = 1'b1;
    end
    grid_acc[at] = total[ACC_W-1:0];
  endfunction

  function automatic void deposit_particle(input in_item_t it);
    axis_pred_t      ax, ay;
    longint unsigned pmass;
    ax = axis_weights(it.pos_x, clamp_size(cur_width, MAX_GRID_X));
    ay = axis_weights(it.pos_y, clamp_size(cur_height, MAX_GRID_Y));
    if (!ax.ok || !ay.ok) return;
    pmass = {32'b0, cur_mass_scale} * {32'b0, it.particle_mass};
    for (int j = 0; j < 3; j++)
      for (int i = 0; i < 3; i++)
        add_to_cell(int'(ax.idx[i]), int'(ay.idx[j]), pmass, ax.w[i], ay.w[j]);
  endfunction

  function automatic out_item_t read_and_clear(input in_item_t it);
    out_item_t r;
    int        at;
    r  = '0;
    if (int'(it.read_col) >= MAX_GRID_X || int'(it.read_row) >= MAX_GRID_Y) return r;
    at = int'(it.read_row) * MAX_GRID_X + int'(it.read_col);
    r.cell_value     = grid_acc[at];
    r.cell_saturated = grid_sat[at];
    grid_acc[at] = '0;
    grid_sat[at] = 1'b0;
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      cur_width      = 9'd256;
      cur_height     = 9'd256;
      cur_inv_cell   = 32'h0001_0000;
      cur_mass_scale = 32'h0001_0000;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_GRID_WIDTH:    cur_width      = cfg_wdata[8:0];
          REG_GRID_HEIGHT:   cur_height     = cfg_wdata[8:0];
          REG_INV_CELL_SIZE: cur_inv_cell   = cfg_wdata;
          REG_MASS_SCALE:    cur_mass_scale = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (in_item.opcode == OP_READ) read_results_q.push_back(read_and_clear(in_item));
        else deposit_particle(in_item);
      end
      if (out_valid && !out_stall) begin
        if (read_results_q.size() == 0) begin
          $error("unexpected result: cell_value %h cell_saturated %b",
                 out_item.cell_value, out_item.cell_saturated);
          fail_count++;
        end else begin
          want = read_results_q.pop_front();
          if (out_item.cell_value !== want.cell_value) begin
            $error("cell_value expected %h actual %h", want.cell_value, out_item.cell_value);
            fail_count++;
          end
          if (out_item.cell_saturated !== want.cell_saturated) begin
            $error("cell_saturated expected %b actual %b",
                   want.cell_saturated, out_item.cell_saturated);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

### sim/tb_tsc_mass_deposit_grid_unit.sv
`timescale 1ns / 1ps
// Testbench top for tsc_mass_deposit_grid_unit: clock, reset, stimulus and verdict.
// Depends on tmdg_pkg, the unit itself and tmdg_density_checker.
module tb_tsc_mass_deposit_grid_unit import tmdg_pkg::*; ();

  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 205;
  localparam int SETTLE       = 40;       // margin for a deposit to drain
  localparam int HOLD_CYCLES  = 400;      // long receiver hold-off
  localparam int CYCLE_LIMIT  = 2000000;  // covers the reset clear pass over all 65536 entries

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_item;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;
  int          fail_count;
  int          reads_pending;

  // Idle mix, set per phase by the main sequence.
  int          send_idle_pct;
  int          recv_stall_pct;
  bit          hold_go;
  bit          hold_on;
  int          cycles;

  // Shadow of the grid size and scale, used only to aim the stimulus.
  int          aim_width, aim_height;
  logic [31:0] aim_inv;

  tsc_mass_deposit_grid_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  tmdg_density_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_item       (in_item),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_item      (out_item),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .reads_pending (reads_pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop: a hang anywhere ends the run as a failure.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tsc_mass_deposit_grid_unit: mismatch");
      $finish;
    end
  end

  // Receiver: random stall, or a solid stall while the hold-off runs.
  always @(posedge clk) begin
    out_stall <= hold_on ? 1'b1 : ($urandom_range(99) < recv_stall_pct);
  end

  // Long hold-off, counted here so the sender keeps pushing and the block backs up.
  initial begin
    hold_on = 1'b0;
    @(posedge clk);
    while (!hold_go) @(posedge clk);
    hold_on = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on = 1'b0;
  end

  // One item on the input channel; returns after the accepting edge.
  // in_valid is only dropped when a gap is actually taken.
  task automatic send_item(input in_item_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // All four registers, then drop the write enable.
  task automatic set_grid(input int w, input int h, input logic [31:0] inv,
                          input logic [31:0] mscale);
    write_reg(REG_GRID_WIDTH, 32'(w));
    write_reg(REG_GRID_HEIGHT, 32'(h));
    write_reg(REG_INV_CELL_SIZE, inv);
    write_reg(REG_MASS_SCALE, mscale);
    cfg_we <= 1'b0;
    @(posedge clk);
    aim_width  = (w < 1) ? 1 : (w > MAX_GRID_X) ? MAX_GRID_X : w;
    aim_height = (h < 1) ? 1 : (h > MAX_GRID_Y) ? MAX_GRID_Y : h;
    aim_inv    = inv;
  endtask

  // Sender pauses until every read result is back, then lets deposits drain.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (reads_pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic in_item_t deposit_at(input logic [31:0] px, input logic [31:0] py,
                                          input logic [31:0] m);
    in_item_t it;
    it               = '0;
    it.opcode        = OP_DEPOSIT;
    it.pos_x         = px;
    it.pos_y         = py;
    it.particle_mass = m;
    it.read_col      = 8'($urandom);
    it.read_row      = 8'($urandom);
    return it;
  endfunction

  function automatic in_item_t read_at(input int col, input int row);
    in_item_t it;
    it          = '0;
    it.opcode   = OP_READ;
    it.pos_x    = $urandom;
    it.pos_y    = $urandom;
    it.particle_mass = $urandom;
    it.read_col = 8'(col);
    it.read_row = 8'(row);
    return it;
  endfunction

  // Position that lands near cell n (plus a random fraction), mostly in range.
  function automatic logic [31:0] aim_pos(input int size);
    longint n, s, p;
    if (aim_inv == 0 || $urandom_range(9) == 0) return $urandom;
    n = longint'($urandom_range(0, 3 * size + 3)) - (size + 1);
    s = (n <<< 32) + longint'($urandom);
    if ($urandom_range(7) == 0) s = (n <<< 32) + 64'h8000_0000;  // near a tie
    p = s / longint'({32'b0, aim_inv});
    if (p > 64'sh7FFF_FFFF || p < -64'sh8000_0000) return $urandom;
    return p[31:0];
  endfunction

  function automatic in_item_t random_item;
    logic [31:0] m;
    if ($urandom_range(99) < 35) begin
      if ($urandom_range(4) == 0) return read_at($urandom_range(255), $urandom_range(255));
      return read_at($urandom_range(0, aim_width - 1), $urandom_range(0, aim_height - 1));
    end
    case ($urandom_range(3))
      0:       m = $urandom_range(65536 * 4);
      1:       m = 32'hFFFF_FFFF - $urandom_range(255);
      default: m = $urandom;
    endcase
    return deposit_at(aim_pos(aim_width), aim_pos(aim_height), m);
  endfunction

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_item        = '0;
    out_stall      = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = REG_GRID_WIDTH;
    cfg_wdata      = '0;
    hold_go        = 1'b0;
    send_idle_pct  = 17;
    recv_stall_pct = 57;
    aim_width      = MAX_GRID_X;
    aim_height     = MAX_GRID_Y;
    aim_inv        = 32'h0001_0000;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Clearing pass after reset holds in_stall high; wait it out.
    while (in_stall) @(posedge clk);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: set_grid(256, 256, 32'h0001_0000, 32'h0001_0000);
        1: set_grid(5, 3, 32'h0001_0000, 32'h0004_0000);
        2: set_grid(0, 1, 32'h0000_8000, 32'hFFFF_FFFF);    // width 0 clamps to 1
        3: set_grid(511, 2, 32'hFFFF_FFFF, 32'h0000_0000);  // width 511 clamps to 256
        4: set_grid(3, 4, 32'h0003_0000, 32'h0001_0000);
        default: set_grid(16, 16, 32'h0002_0000, 32'h0010_0000);
      endcase
      // Idle mix: sender light/receiver heavy, then reversed, then none.
      send_idle_pct  = (ph < 2) ? 17 : (ph < 4) ? 57 : 0;
      recv_stall_pct = (ph < 2) ? 57 : (ph < 4) ? 17 : 0;

      if (ph == 0) begin
        // Grid 256x256, unit scale: rounding, ties, wrap, range edges, saturation.
        send_item(deposit_at(32'h0000_0000, 32'h0000_0000, 32'h0001_0000));
        send_item(read_at(0, 0));
        send_item(read_at(255, 0));
        send_item(read_at(1, 255));
        send_item(deposit_at(32'h0000_8000, 32'h0001_8000, 32'h0002_0000)); // ties
        send_item(deposit_at(32'hFFFF_8000, 32'hFFFE_8000, 32'h0002_0000)); // negative ties
        send_item(read_at(0, 1));
        send_item(read_at(255, 254));
        send_item(deposit_at(32'h0000_0000, 32'h0000_0000, 32'h0000_0000)); // zero offset
        send_item(deposit_at(32'hFF01_0000, 32'h01FE_0000, 32'h0001_0000)); // -255 and 510, the ends of the range
        send_item(read_at(1, 254));
        send_item(deposit_at(32'hFF00_0000, 32'h0005_0000, 32'h0001_0000)); // -256 dropped
        send_item(deposit_at(32'h0005_0000, 32'h01FF_0000, 32'h0001_0000)); // 511 dropped
        send_item(deposit_at(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF)); // field extremes
        send_item(deposit_at(32'h000A_0000, 32'h000A_0000, 32'hFFFF_FFFF));
        send_item(deposit_at(32'h000A_0000, 32'h000A_0000, 32'hFFFF_FFFF)); // center saturates
        send_item(read_at(10, 10));
        send_item(read_at(10, 10));  // cleared by the read before
        send_item(read_at(11, 10));
        send_item(read_at(255, 255));
      end

      // Long receiver hold-off during the second phase: reads back up.
      if (ph == 1) hold_go = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) send_item(random_item());
      drain();
    end

    if (fail_count == 0) begin
      $display("tsc_mass_deposit_grid_unit: match");
    end else begin
      $display("tsc_mass_deposit_grid_unit: mismatch");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/tmdg_pkg.sv
hw/rtl/tmdg_axis.sv
hw/rtl/tmdg_contrib.sv
hw/rtl/tmdg_grid_mem.sv
hw/rtl/tsc_mass_deposit_grid_unit.sv
sim/tmdg_density_checker.sv
sim/tb_tsc_mass_deposit_grid_unit.sv
